[hdl/entity_visibility_tier_classifier_assert.svh]
// Assertion macros for the entity visibility tier classifier checker.
// Needs signals named clock and reset in the including scope.
`ifndef ENTITY_VISIBILITY_TIER_CLASSIFIER_ASSERT_SVH
`define ENTITY_VISIBILITY_TIER_CLASSIFIER_ASSERT_SVH
// same-cycle implication
`define EVTC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define EVTC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

[hdl/evtc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the entity visibility tier classifier.
// No dependencies.
package evtc_pkg;
   localparam int SLOT_W    = 6;
   localparam int CNT_W     = 7;
   localparam int POS_W     = 32;
   localparam int TRIG_W    = 16;
   localparam int DIST_W    = 24;
   localparam int CSR_IDX_W = 3;
   localparam int OUT_DEPTH = 16;
   localparam int OUT_AW    = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_NEAR_DIST = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MID_DIST  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FAR_DIST  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NEAR_FACE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MID_FACE  = 3'd4;

   localparam logic [DIST_W-1:0] NEAR_DIST_RST = 24'd8960;
   localparam logic [DIST_W-1:0] MID_DIST_RST  = 24'd20480;
   localparam logic [DIST_W-1:0] FAR_DIST_RST  = 24'd38400;
   localparam logic signed [TRIG_W-1:0] NEAR_FACE_RST = -16'sd4096;
   localparam logic signed [TRIG_W-1:0] MID_FACE_RST  = -16'sd9011;
   localparam logic signed [TRIG_W-1:0] FACING_ONE    = 16'sd16384;

   typedef enum logic {OP_WRITE = 1'b0, OP_UPDATE = 1'b1} op_type;

   typedef enum logic [1:0] {
      TIER_FULL    = 2'd0,
      TIER_REDUCED = 2'd1,
      TIER_MINIMAL = 2'd2,
      TIER_DORMANT = 2'd3
   } tier_type;

   typedef struct packed {
      logic [DIST_W-1:0]        near_dist;
      logic [DIST_W-1:0]        mid_dist;
      logic [DIST_W-1:0]        far_dist;
      logic signed [TRIG_W-1:0] near_face;
      logic signed [TRIG_W-1:0] mid_face;
   } cfg_type;

   typedef struct packed {
      logic                     is_update;
      logic [SLOT_W-1:0]        slot;
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_z;
      logic                     alive;
      logic signed [TRIG_W-1:0] sin_yaw;
      logic signed [TRIG_W-1:0] cos_yaw;
   } cmd_type;

   typedef struct packed {
      logic              empty;
      logic              last;
      logic              alive;
      logic [SLOT_W-1:0] slot;
   } meta_type;

   typedef struct packed {
      logic                     valid;
      meta_type                 meta;
      logic signed [POS_W-1:0]  cam_x;
      logic signed [POS_W-1:0]  cam_z;
      logic signed [TRIG_W-1:0] sin_yaw;
      logic signed [TRIG_W-1:0] cos_yaw;
   } issue_type;

   typedef struct packed {
      logic                       valid_entity;
      logic [SLOT_W-1:0]          slot;
      logic [1:0]                 tier;
      logic                       last;
      logic [3:0][CNT_W-1:0]      counts;
   } result_type;
endpackage

[hdl/evtc_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module evtc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[hdl/evtc_front.sv]
`timescale 1ns / 1ps
// Front end: accepts items, drops rejected writes, queues commands.
// Depends on evtc_pkg.
module evtc_front #(
   parameter int SLOT_COUNT = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_op,
   input  logic [7:0]            req_slot_index,
   input  logic [31:0]           req_entity_id,
   input  logic signed [31:0]    req_pos_x,
   input  logic signed [31:0]    req_pos_z,
   input  logic                  req_alive,
   input  logic signed [15:0]    req_sin_yaw,
   input  logic signed [15:0]    req_cos_yaw,
   output logic                  cmd_valid,
   input  logic                  cmd_ready,
   output evtc_pkg::cmd_type     cmd
);
   import evtc_pkg::*;

   cmd_type    q_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop, keep;
   cmd_type    new_cmd;

   assign keep = (op_type'(req_op) == OP_UPDATE) ||
                 (({1'b0, req_slot_index} < 9'(SLOT_COUNT)) && (req_entity_id != 32'd0));
   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready && keep;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = q_ff[rp_ff];

   always_comb begin
      new_cmd.is_update = (op_type'(req_op) == OP_UPDATE);
      new_cmd.slot      = req_slot_index[SLOT_W-1:0];
      new_cmd.pos_x     = req_pos_x;
      new_cmd.pos_z     = req_pos_z;
      new_cmd.alive     = req_alive;
      new_cmd.sin_yaw   = req_sin_yaw;
      new_cmd.cos_yaw   = req_cos_yaw;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= new_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wp_ff <= ~wp_ff;
         end
         if (pop) begin
            rp_ff <= ~rp_ff;
         end
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end
endmodule

[hdl/evtc_classify.sv]
`timescale 1ns / 1ps
// Pipelined slot classifier: distance and facing tests, one slot a cycle.
// Depends on evtc_pkg.
module evtc_classify (
   input  logic                  clock,
   input  logic                  reset,
   input  evtc_pkg::cfg_type     cfg,
   input  evtc_pkg::issue_type   issue,
   input  logic [63:0]           slot_pos,
   output logic                  res_valid,
   output evtc_pkg::result_type  res
);
   import evtc_pkg::*;

   function automatic logic facing_above(input logic s_zero, input logic p_pos,
                                         input logic p_nonneg,
                                         input logic signed [15:0] f,
                                         input logic gt, input logic lt);
      logic r;
      if (s_zero) begin
         r = (f < FACING_ONE);
      end else if (!f[15]) begin
         r = p_pos && gt;
      end else begin
         r = p_nonneg || lt;
      end
      return r;
   endfunction

   // stage valids and metadata
   logic [7:0] v_ff;
   meta_type   m0_ff, m1_ff, m2_ff, m3_ff, m4_ff, m5_ff, m6_ff;
   // stage 0
   logic signed [31:0] cx0_ff, cz0_ff;
   logic signed [15:0] sn0_ff, cs0_ff, sn1_ff, cs1_ff, sn2_ff, cs2_ff;
   // stage 1
   logic signed [32:0] dx1_ff, dz1_ff;
   // stage 2
   logic [23:0]        ax2_ff, az2_ff;
   logic signed [24:0] x2_ff, z2_ff;
   logic               huge2_ff, huge3_ff, huge4_ff, huge5_ff, huge6_ff;
   // stage 3
   logic [47:0]        sqx3_ff, sqz3_ff, nd3_ff, md3_ff, fd3_ff, nd4_ff, md4_ff, fd4_ff;
   logic signed [40:0] px3_ff, pz3_ff;
   logic [31:0]        afn3_ff, afm3_ff, afn4_ff, afm4_ff;
   // stage 4
   logic [48:0]        s4_ff;
   logic signed [41:0] p4_ff;
   // stage 5
   logic [39:0]        hh5_ff, hl5_ff, ll5_ff;
   logic [56:0]        fnl5_ff, fml5_ff;
   logic [55:0]        fnh5_ff, fmh5_ff;
   logic [2:0]         lt5_ff, lt6_ff;
   logic               sz5_ff, pp5_ff, pn5_ff, sz6_ff, pp6_ff, pn6_ff;
   // stage 6
   logic [79:0]        ap6_ff, fsn6_ff, fsm6_ff;
   // counts
   logic [3:0][CNT_W-1:0] acc_ff, cnt_w;

   logic signed [32:0] dx_w, dz_w;
   logic [32:0]        ax_w, az_w;
   logic [15:0]        afn_w, afm_w;
   logic [41:0]        ap_w;
   logic               fa_n, fa_m;
   tier_type           tier_w;
   result_type         res_w;

   assign dx_w = $signed({slot_pos[63], slot_pos[63:32]}) - $signed({cx0_ff[31], cx0_ff});
   assign dz_w = $signed({slot_pos[31], slot_pos[31:0]}) - $signed({cz0_ff[31], cz0_ff});
   assign ax_w = dx1_ff[32] ? 33'(-dx1_ff) : 33'(dx1_ff);
   assign az_w = dz1_ff[32] ? 33'(-dz1_ff) : 33'(dz1_ff);
   assign afn_w = cfg.near_face[15] ? 16'(-cfg.near_face) : 16'(cfg.near_face);
   assign afm_w = cfg.mid_face[15] ? 16'(-cfg.mid_face) : 16'(cfg.mid_face);
   assign ap_w  = p4_ff[41] ? 42'(-p4_ff) : 42'(p4_ff);

   assign fa_n = facing_above(sz6_ff, pp6_ff, pn6_ff, cfg.near_face,
                              ap6_ff > fsn6_ff, ap6_ff < fsn6_ff);
   assign fa_m = facing_above(sz6_ff, pp6_ff, pn6_ff, cfg.mid_face,
                              ap6_ff > fsm6_ff, ap6_ff < fsm6_ff);

   always_comb begin
      if (!m6_ff.alive || huge6_ff) begin
         tier_w = TIER_DORMANT;
      end else if (lt6_ff[0] && fa_n) begin
         tier_w = TIER_FULL;
      end else if (lt6_ff[1] && fa_m) begin
         tier_w = TIER_REDUCED;
      end else if (lt6_ff[2]) begin
         tier_w = TIER_MINIMAL;
      end else begin
         tier_w = TIER_DORMANT;
      end
      cnt_w         = acc_ff;
      cnt_w[tier_w] = acc_ff[tier_w] + 7'd1;
      res_w.valid_entity = 1'b1;
      res_w.slot         = m6_ff.slot;
      res_w.tier         = tier_w;
      res_w.last         = m6_ff.last;
      res_w.counts       = m6_ff.last ? cnt_w : '0;
      if (m6_ff.empty) begin
         res_w = '0;
         res_w.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      // stage 0
      m0_ff  <= issue.meta;
      cx0_ff <= issue.cam_x;
      cz0_ff <= issue.cam_z;
      sn0_ff <= issue.sin_yaw;
      cs0_ff <= issue.cos_yaw;
      // stage 1
      m1_ff  <= m0_ff;
      dx1_ff <= dx_w;
      dz1_ff <= dz_w;
      sn1_ff <= sn0_ff;
      cs1_ff <= cs0_ff;
      // stage 2
      m2_ff    <= m1_ff;
      ax2_ff   <= ax_w[23:0];
      az2_ff   <= az_w[23:0];
      huge2_ff <= (|ax_w[32:24]) || (|az_w[32:24]);
      x2_ff    <= dx1_ff[24:0];
      z2_ff    <= dz1_ff[24:0];
      sn2_ff   <= sn1_ff;
      cs2_ff   <= cs1_ff;
      // stage 3
      m3_ff    <= m2_ff;
      huge3_ff <= huge2_ff;
      sqx3_ff  <= ax2_ff * ax2_ff;
      sqz3_ff  <= az2_ff * az2_ff;
      px3_ff   <= x2_ff * sn2_ff;
      pz3_ff   <= z2_ff * cs2_ff;
      nd3_ff   <= cfg.near_dist * cfg.near_dist;
      md3_ff   <= cfg.mid_dist * cfg.mid_dist;
      fd3_ff   <= cfg.far_dist * cfg.far_dist;
      afn3_ff  <= afn_w * afn_w;
      afm3_ff  <= afm_w * afm_w;
      // stage 4
      m4_ff    <= m3_ff;
      huge4_ff <= huge3_ff;
      s4_ff    <= 49'(sqx3_ff) + 49'(sqz3_ff);
      p4_ff    <= 42'(px3_ff) + 42'(pz3_ff);
      nd4_ff   <= nd3_ff;
      md4_ff   <= md3_ff;
      fd4_ff   <= fd3_ff;
      afn4_ff  <= afn3_ff;
      afm4_ff  <= afm3_ff;
      // stage 5
      m5_ff    <= m4_ff;
      huge5_ff <= huge4_ff;
      hh5_ff   <= ap_w[39:20] * ap_w[39:20];
      hl5_ff   <= ap_w[39:20] * ap_w[19:0];
      ll5_ff   <= ap_w[19:0] * ap_w[19:0];
      fnl5_ff  <= afn4_ff * s4_ff[24:0];
      fnh5_ff  <= afn4_ff * s4_ff[48:25];
      fml5_ff  <= afm4_ff * s4_ff[24:0];
      fmh5_ff  <= afm4_ff * s4_ff[48:25];
      lt5_ff   <= {s4_ff < {1'b0, fd4_ff}, s4_ff < {1'b0, md4_ff}, s4_ff < {1'b0, nd4_ff}};
      sz5_ff   <= (s4_ff == 49'd0);
      pp5_ff   <= !p4_ff[41] && (p4_ff != 42'sd0);
      pn5_ff   <= !p4_ff[41];
      // stage 6
      m6_ff    <= m5_ff;
      huge6_ff <= huge5_ff;
      ap6_ff   <= (80'(hh5_ff) << 40) + (80'(hl5_ff) << 21) + 80'(ll5_ff);
      fsn6_ff  <= (80'(fnh5_ff) << 25) + 80'(fnl5_ff);
      fsm6_ff  <= (80'(fmh5_ff) << 25) + 80'(fml5_ff);
      lt6_ff   <= lt5_ff;
      sz6_ff   <= sz5_ff;
      pp6_ff   <= pp5_ff;
      pn6_ff   <= pn5_ff;
      // stage 7
      res      <= res_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff   <= '0;
         acc_ff <= '0;
      end else begin
         v_ff <= {v_ff[6:0], issue.valid};
         if (v_ff[6] && !m6_ff.empty) begin
            acc_ff <= m6_ff.last ? '0 : cnt_w;
         end
      end
   end

   assign res_valid = v_ff[7];
endmodule

[hdl/evtc_back.sv]
`timescale 1ns / 1ps
// Back end: slot table, update walk sequencer, classifier and result queue.
// Depends on evtc_pkg, evtc_ram and evtc_classify.
module evtc_back #(
   parameter int SLOT_COUNT = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  evtc_pkg::cfg_type     cfg,
   input  logic                  cmd_valid,
   output logic                  cmd_ready,
   input  evtc_pkg::cmd_type     cmd,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output evtc_pkg::result_type  rsp_item
);
   import evtc_pkg::*;

   localparam int AW = SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1;

   typedef enum logic {ST_IDLE, ST_WALK} state_type;

   state_type           state_ff;
   logic [SLOT_W-1:0]   idx_ff;
   logic [SLOT_COUNT-1:0] alive_ff;
   logic [CNT_W-1:0]    used_ff;
   cmd_type             cam_ff;
   logic [OUT_AW:0]     rsv_ff, cnt_ff;
   logic [OUT_AW-1:0]   wp_ff, rp_ff;
   result_type          q_ff [OUT_DEPTH];

   logic       credit, do_write, do_empty, do_start, do_walk, walk_last, pop;
   logic [CNT_W-1:0] wr_top;
   issue_type  issue;
   logic [63:0] pos_rd;
   logic       res_valid;
   result_type res;

   assign credit    = (rsv_ff < (OUT_AW+1)'(OUT_DEPTH));
   assign do_write  = (state_ff == ST_IDLE) && cmd_valid && !cmd.is_update;
   assign do_empty  = (state_ff == ST_IDLE) && cmd_valid && cmd.is_update &&
                      (used_ff == '0) && credit;
   assign do_start  = (state_ff == ST_IDLE) && cmd_valid && cmd.is_update &&
                      (used_ff != '0);
   assign do_walk   = (state_ff == ST_WALK) && credit;
   assign walk_last = (({1'b0, idx_ff} + 7'd1) == used_ff);
   assign cmd_ready = do_write || do_empty || do_start;
   assign wr_top    = {1'b0, cmd.slot} + 7'd1;
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (cnt_ff != '0);
   assign rsp_item  = q_ff[rp_ff];

   always_comb begin
      issue.valid      = do_empty || do_walk;
      issue.meta.empty = do_empty;
      issue.meta.last  = do_empty || walk_last;
      issue.meta.alive = alive_ff[idx_ff[AW-1:0]];
      issue.meta.slot  = do_empty ? '0 : idx_ff;
      issue.cam_x      = cam_ff.pos_x;
      issue.cam_z      = cam_ff.pos_z;
      issue.sin_yaw    = cam_ff.sin_yaw;
      issue.cos_yaw    = cam_ff.cos_yaw;
   end

   evtc_ram #(.WIDTH(64), .DEPTH(SLOT_COUNT)) u_pos_ram (
      .clock   (clock),
      .wr_en   (do_write),
      .wr_addr (cmd.slot[AW-1:0]),
      .wr_data ({cmd.pos_x, cmd.pos_z}),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (pos_rd)
   );

   evtc_classify u_classify (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .issue     (issue),
      .slot_pos  (pos_rd),
      .res_valid (res_valid),
      .res       (res)
   );

   always_ff @(posedge clock) begin
      if (do_start) begin
         cam_ff <= cmd;
      end
      if (res_valid) begin
         q_ff[wp_ff] <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         alive_ff <= '0;
         used_ff  <= '0;
         rsv_ff   <= '0;
         cnt_ff   <= '0;
         wp_ff    <= '0;
         rp_ff    <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (do_write) begin
                  alive_ff[cmd.slot[AW-1:0]] <= cmd.alive;
                  if (wr_top > used_ff) begin
                     used_ff <= wr_top;
                  end
               end
               if (do_start) begin
                  state_ff <= ST_WALK;
                  idx_ff   <= '0;
               end
            end
            ST_WALK: begin
               if (do_walk) begin
                  idx_ff <= idx_ff + 6'd1;
                  if (walk_last) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
         rsv_ff <= rsv_ff + (OUT_AW+1)'(issue.valid) - (OUT_AW+1)'(pop);
         cnt_ff <= cnt_ff + (OUT_AW+1)'(res_valid) - (OUT_AW+1)'(pop);
         if (res_valid) begin
            wp_ff <= wp_ff + 1'b1;
         end
         if (pop) begin
            rp_ff <= rp_ff + 1'b1;
         end
      end
   end
endmodule

[hdl/entity_visibility_tier_classifier.sv]
`timescale 1ns / 1ps
// Write item: handled in the back end after the two-entry command queue; no result.
// Update item: one slot per cycle, while the 16-entry result queue has credit, through the
// eight-stage classifier pipeline; the result queue absorbs output stalls.
// Reset clears alive flags, the slot count, queues and registers to defaults; no clear pass.
module entity_visibility_tier_classifier #(
   parameter int SLOT_COUNT = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_op,
   input  logic [7:0]           req_slot_index,
   input  logic [31:0]          req_entity_id,
   input  logic signed [31:0]   req_pos_x,
   input  logic signed [31:0]   req_pos_z,
   input  logic                 req_alive,
   input  logic signed [15:0]   req_sin_yaw,
   input  logic signed [15:0]   req_cos_yaw,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_result_valid_entity,
   output logic [5:0]           rsp_result_slot,
   output logic [1:0]           rsp_tier,
   output logic                 rsp_is_last,
   output logic [6:0]           rsp_full_count,
   output logic [6:0]           rsp_reduced_count,
   output logic [6:0]           rsp_minimal_count,
   output logic [6:0]           rsp_dormant_count,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [evtc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [23:0]          csr_wdata
);
   import evtc_pkg::*;

   cfg_type    cfg_ff;
   logic       cmd_valid, cmd_ready;
   cmd_type    cmd;
   result_type rsp_item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.near_dist <= NEAR_DIST_RST;
         cfg_ff.mid_dist  <= MID_DIST_RST;
         cfg_ff.far_dist  <= FAR_DIST_RST;
         cfg_ff.near_face <= NEAR_FACE_RST;
         cfg_ff.mid_face  <= MID_FACE_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_NEAR_DIST: cfg_ff.near_dist <= csr_wdata;
            CSR_MID_DIST:  cfg_ff.mid_dist  <= csr_wdata;
            CSR_FAR_DIST:  cfg_ff.far_dist  <= csr_wdata;
            CSR_NEAR_FACE: cfg_ff.near_face <= csr_wdata[15:0];
            CSR_MID_FACE:  cfg_ff.mid_face  <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   evtc_front #(.SLOT_COUNT(SLOT_COUNT)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_slot_index (req_slot_index),
      .req_entity_id  (req_entity_id),
      .req_pos_x      (req_pos_x),
      .req_pos_z      (req_pos_z),
      .req_alive      (req_alive),
      .req_sin_yaw    (req_sin_yaw),
      .req_cos_yaw    (req_cos_yaw),
      .cmd_valid      (cmd_valid),
      .cmd_ready      (cmd_ready),
      .cmd            (cmd)
   );

   evtc_back #(.SLOT_COUNT(SLOT_COUNT)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   assign rsp_result_valid_entity = rsp_item.valid_entity;
   assign rsp_result_slot         = rsp_item.slot;
   assign rsp_tier                = rsp_item.tier;
   assign rsp_is_last             = rsp_item.last;
   assign rsp_full_count          = rsp_item.counts[TIER_FULL];
   assign rsp_reduced_count       = rsp_item.counts[TIER_REDUCED];
   assign rsp_minimal_count       = rsp_item.counts[TIER_MINIMAL];
   assign rsp_dormant_count       = rsp_item.counts[TIER_DORMANT];
endmodule

[hdl/evtc_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the entity visibility tier classifier, bound to the top.
// Depends on entity_visibility_tier_classifier_assert.svh.
`include "entity_visibility_tier_classifier_assert.svh"
module evtc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_result_valid_entity,
   input logic [5:0] rsp_result_slot,
   input logic [1:0] rsp_tier,
   input logic       rsp_is_last,
   input logic [6:0] rsp_full_count,
   input logic [6:0] rsp_reduced_count,
   input logic [6:0] rsp_minimal_count,
   input logic [6:0] rsp_dormant_count
);
   logic [7:0] count_sum;
   logic       counts_zero;

   assign count_sum = 8'(rsp_full_count) + 8'(rsp_reduced_count) +
                      8'(rsp_minimal_count) + 8'(rsp_dormant_count);
   assign counts_zero = (count_sum == 8'd0);

   `EVTC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_tier) && $stable(rsp_result_slot), "result changed while stalled")
   `EVTC_ASSERT_SAME(a_counts_only_last, rsp_valid && !rsp_is_last, counts_zero, "counts on a non-last result")
   `EVTC_ASSERT_SAME(a_empty_shape, rsp_valid && !rsp_result_valid_entity, rsp_is_last && counts_zero && rsp_result_slot == 6'd0, "malformed empty-table result")
   `EVTC_ASSERT_SAME(a_count_total, rsp_valid && rsp_is_last && rsp_result_valid_entity, count_sum == 8'(rsp_result_slot) + 8'd1, "tier counts do not cover all slots")
endmodule

bind entity_visibility_tier_classifier evtc_checker u_checker (.*);

[test/tb_entity_visibility_tier_classifier.sv]
`timescale 1ns / 1ps
// Testbench for entity_visibility_tier_classifier: random and directed slot writes and
// camera updates, checked against a built-in tier predictor. Depends on evtc_pkg.
module tb_entity_visibility_tier_classifier;
   import evtc_pkg::*;

   typedef struct {
      bit          valid_entity;
      bit [5:0]    slot;
      bit [1:0]    tier;
      bit          last;
      bit [6:0]    n_full, n_reduced, n_minimal, n_dormant;
   } tier_result_type;

   class tier_scoreboard;
      tier_result_type tiers_due[$];
      int           errors;
      longint       near_lim, mid_lim, far_lim, near_face, mid_face;
      bit           slot_live[64];
      longint       slot_px[64], slot_pz[64];
      int           used_slots;

      function new();
         near_lim = 8960;
         mid_lim = 20480;
         far_lim = 38400;
         near_face = -4096;
         mid_face = -9011;
         used_slots = 0;
         errors = 0;
         foreach (slot_live[i]) slot_live[i] = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [23:0] data);
         case (idx)
            CSR_NEAR_DIST: near_lim = data;
            CSR_MID_DIST:  mid_lim = data;
            CSR_FAR_DIST:  far_lim = data;
            CSR_NEAR_FACE: near_face = longint'($signed(data[15:0]));
            CSR_MID_FACE:  mid_face = longint'($signed(data[15:0]));
            default: ;
         endcase
      endfunction

      function int pending();
         return tiers_due.size();
      endfunction

      function bit faces(longint p, longint s, longint f);
         bit [127:0] ap, af, lhs, rhs;
         ap = (p < 0) ? -p : p;
         af = (f < 0) ? -f : f;
         if (s == 0) return f < 16384;
         lhs = ap * ap;
         rhs = af * af * 128'(s);
         if (f >= 0) return p > 0 && lhs > rhs;
         if (p >= 0) return 1;
         return lhs < rhs;
      endfunction

      function tier_type grade(int i, longint cx, longint cz, longint sn, longint cs);
         longint x, z, ax, az, s, p;
         if (!slot_live[i]) return TIER_DORMANT;
         x = slot_px[i] - cx;
         z = slot_pz[i] - cz;
         ax = (x < 0) ? -x : x;
         az = (z < 0) ? -z : z;
         if (ax >= (64'd1 << 24) || az >= (64'd1 << 24)) return TIER_DORMANT;
         s = ax * ax + az * az;
         p = x * sn + z * cs;
         if (s < near_lim * near_lim && faces(p, s, near_face)) return TIER_FULL;
         if (s < mid_lim * mid_lim && faces(p, s, mid_face)) return TIER_REDUCED;
         if (s < far_lim * far_lim) return TIER_MINIMAL;
         return TIER_DORMANT;
      endfunction

      function void note_item(op_type op, bit [7:0] idx, bit [31:0] id,
                              logic signed [31:0] px, logic signed [31:0] pz, bit alive,
                              logic signed [15:0] sn, logic signed [15:0] cs);
         tier_result_type r;
         int tally[4];
         if (op == OP_WRITE) begin
            if (idx >= 64 || id == 0) return;
            slot_live[idx] = alive;
            slot_px[idx] = longint'(px);
            slot_pz[idx] = longint'(pz);
            if (used_slots < idx + 1) used_slots = idx + 1;
            return;
         end
         r = '{default: 0};
         if (used_slots == 0) begin
            r.last = 1;
            tiers_due.push_back(r);
            return;
         end
         tally = '{0, 0, 0, 0};
         for (int i = 0; i < used_slots; i++) begin
            r = '{default: 0};
            r.valid_entity = 1;
            r.slot = 6'(i);
            r.tier = grade(i, longint'(px), longint'(pz), longint'(sn), longint'(cs));
            tally[r.tier]++;
            if (i == used_slots - 1) begin
               r.last = 1;
               r.n_full = 7'(tally[0]);
               r.n_reduced = 7'(tally[1]);
               r.n_minimal = 7'(tally[2]);
               r.n_dormant = 7'(tally[3]);
            end
            tiers_due.push_back(r);
         end
      endfunction

      task report(string what, int got, int want);
         errors++;
         $display("mismatch %s: got %0d expected %0d", what, got, want);
      endtask

      task check_result(tier_result_type got);
         tier_result_type want;
         if (tiers_due.size() == 0) begin
            report("unexpected result, slot", got.slot, -1);
            return;
         end
         want = tiers_due.pop_front();
         if (got.valid_entity != want.valid_entity)
            report("valid_entity", got.valid_entity, want.valid_entity);
         if (got.slot != want.slot) report("slot", got.slot, want.slot);
         if (got.tier != want.tier) report("tier", got.tier, want.tier);
         if (got.last != want.last) report("is_last", got.last, want.last);
         if (got.n_full != want.n_full) report("full_count", got.n_full, want.n_full);
         if (got.n_reduced != want.n_reduced)
            report("reduced_count", got.n_reduced, want.n_reduced);
         if (got.n_minimal != want.n_minimal)
            report("minimal_count", got.n_minimal, want.n_minimal);
         if (got.n_dormant != want.n_dormant)
            report("dormant_count", got.n_dormant, want.n_dormant);
      endtask
   endclass

   logic clock, reset;
   logic req_valid, req_ready, req_op, req_alive;
   logic [7:0] req_slot_index;
   logic [31:0] req_entity_id;
   logic signed [31:0] req_pos_x, req_pos_z;
   logic signed [15:0] req_sin_yaw, req_cos_yaw;
   logic rsp_valid, rsp_ready, rsp_result_valid_entity, rsp_is_last;
   logic [5:0] rsp_result_slot;
   logic [1:0] rsp_tier;
   logic [6:0] rsp_full_count, rsp_reduced_count, rsp_minimal_count, rsp_dormant_count;
   logic csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [23:0] csr_wdata;

   tier_scoreboard tiers = new();
   bit quiet_send;
   int results_seen;

   entity_visibility_tier_classifier dut (.*);

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   initial begin
      #20_000_000;
      $display("tb_entity_visibility_tier_classifier NOT OK");
      $finish;
   end

   task send_item(op_type op, bit [7:0] idx, bit [31:0] id, bit [31:0] px, bit [31:0] pz,
                  bit alive, bit [15:0] sn, bit [15:0] cs);
      int gap;
      gap = quiet_send ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_slot_index <= idx;
      req_entity_id <= id;
      req_pos_x <= px;
      req_pos_z <= pz;
      req_alive <= alive;
      req_sin_yaw <= sn;
      req_cos_yaw <= cs;
      do @(posedge clock); while (!req_ready);
      tiers.note_item(op, idx, id, px, pz, alive, sn, cs);
   endtask

   task write_slot(bit [7:0] idx, bit [31:0] px, bit [31:0] pz, bit alive);
      send_item(OP_WRITE, idx, $urandom_range(1, 32'hffff_ffff), px, pz, alive,
                16'($urandom), 16'($urandom));
   endtask

   task update_camera(bit [31:0] px, bit [31:0] pz, bit [15:0] sn, bit [15:0] cs);
      send_item(OP_UPDATE, 8'($urandom), $urandom, px, pz, 1'($urandom), sn, cs);
   endtask

   task drain();
      req_valid <= 1'b0;
      while (tiers.pending() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task write_reg(logic [CSR_IDX_W-1:0] idx, logic [23:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      tiers.set_reg(idx, data);
   endtask

   task load_regs(int nd, int md, int fd, int nf, int mf);
      write_reg(CSR_NEAR_DIST, 24'(nd));
      write_reg(CSR_MID_DIST, 24'(md));
      write_reg(CSR_FAR_DIST, 24'(fd));
      write_reg(CSR_NEAR_FACE, 24'(nf));
      write_reg(CSR_MID_FACE, 24'(mf));
      csr_valid <= 1'b0;
   endtask

   function bit [15:0] trig_draw();
      case ($urandom_range(0, 5))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'sd0;
         default: return 16'($signed($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   function bit [31:0] near_draw(int base);
      if ($urandom_range(0, 9) == 0) return $urandom;
      return base + $signed($urandom_range(0, 120000)) - 60000;
   endfunction

   task random_items(int count);
      bit [7:0] idx;
      bit [31:0] id;
      for (int k = 0; k < count; k++) begin
         quiet_send = (k % 40) < 8;
         if ($urandom_range(0, 3) == 0) begin
            update_camera(near_draw(0), near_draw(0), trig_draw(), trig_draw());
         end else begin
            idx = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
            id = ($urandom_range(0, 15) == 0) ? 0 : $urandom;
            send_item(OP_WRITE, idx, id, near_draw(0), near_draw(0),
                      $urandom_range(0, 7) != 0, 16'($urandom), 16'($urandom));
         end
      end
      quiet_send = 0;
   endtask

   initial begin
      int gap;
      tier_result_type got;
      results_seen = 0;
      @(negedge reset);
      forever begin
         if (results_seen == 60) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
         end
         gap = ((results_seen / 100) % 3 == 1) ? 0 : $urandom_range(0, 4);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got.valid_entity = rsp_result_valid_entity;
         got.slot = rsp_result_slot;
         got.tier = rsp_tier;
         got.last = rsp_is_last;
         got.n_full = rsp_full_count;
         got.n_reduced = rsp_reduced_count;
         got.n_minimal = rsp_minimal_count;
         got.n_dormant = rsp_dormant_count;
         tiers.check_result(got);
         results_seen++;
      end
   end

   initial begin
      reset <= 1'b1;
      rsp_ready <= 1'b0;
      req_valid <= 1'b0;
      req_op <= OP_WRITE;
      req_slot_index <= '0;
      req_entity_id <= '0;
      req_pos_x <= '0;
      req_pos_z <= '0;
      req_alive <= 1'b0;
      req_sin_yaw <= '0;
      req_cos_yaw <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_NEAR_DIST;
      csr_wdata <= '0;
      quiet_send = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table, rejected writes, then a small table
      update_camera(0, 0, 0, 16'sd16384);
      send_item(OP_WRITE, 0, 0, 100, 100, 1, 0, 0);
      send_item(OP_WRITE, 64, 5, 100, 100, 1, 0, 0);
      send_item(OP_WRITE, 255, 32'hffff_ffff, 100, 100, 1, 0, 0);
      update_camera(0, 0, 0, 16'sd16384);
      write_slot(0, 0, 0, 1);
      write_slot(1, 1000, 2000, 1);
      write_slot(2, 500, 500, 0);
      write_slot(3, 32'h7fff_ffff, 32'h8000_0000, 1);
      write_slot(4, 20000, -5000, 1);
      write_slot(5, -30000, 0, 1);
      write_slot(7, -9000, 9000, 1);
      update_camera(0, 0, 0, 16'sd16384);
      update_camera(0, 0, 16'sd16384, 0);
      update_camera(0, 0, -16'sd16384, -16'sd16384);
      update_camera(32'h8000_0000, 32'h7fff_ffff, 0, 16'sd16384);
      update_camera(20000, -5000, 16'sd16384, 16'sd16384);
      update_camera(-1, 1, trig_draw(), trig_draw());
      random_items(70);
      drain();

      load_regs(0, 0, 0, -16384, -16384);
      update_camera(0, 0, 0, 16'sd16384);
      random_items(60);
      drain();

      load_regs(24'hff_ffff, 24'hff_ffff, 24'hff_ffff, 16384, 16384);
      update_camera(0, 0, 0, 16'sd16384);
      random_items(80);
      drain();

      load_regs(12000, 30000, 60000, 0, -16384);
      random_items(80);
      drain();

      load_regs(40000, 20000, 50000, 8000, 4000);
      random_items(80);
      drain();

      if (tiers.errors == 0) begin
         $display("tb_entity_visibility_tier_classifier OK");
      end else begin
         $display("tb_entity_visibility_tier_classifier NOT OK");
      end
      $finish;
   end
endmodule
